// File: design/spvep_pkg.sv
// Package: shared types, codes and helpers for the SPIR-V entry point scanner.
`timescale 1ns / 1ps

package spvep_pkg;

  localparam logic [31:0] MAGIC_WORD      = 32'h0723_0203;
  localparam logic [15:0] OP_ENTRY_POINT  = 16'd15;
  localparam logic [15:0] OP_EXEC_MODE    = 16'd16;
  localparam logic [31:0] MODE_LOCAL_SIZE = 32'd17;
  localparam logic [31:0] MODEL_LIMIT     = 32'd6;
  localparam logic [2:0]  HEADER_WORDS    = 3'd4;
  localparam logic [30:0] ALL_STAGES      = 31'h7FFF_FFFF;

  localparam logic [1:0] KIND_ENTRY      = 2'd0;
  localparam logic [1:0] KIND_LOCAL_SIZE = 2'd1;
  localparam logic [1:0] KIND_SUMMARY    = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_MAGIC = 2'd1;
  localparam logic [1:0] STATUS_MALFORMED = 2'd2;

  localparam int RES_TDATA_W = 168;

  typedef struct packed {
    logic [1:0]  kind;
    logic        last_of_run;
    logic [31:0] result_id;
    logic [30:0] stage_mask;
    logic [31:0] size_x;
    logic [31:0] size_y;
    logic [31:0] size_z;
    logic [1:0]  status;
  } res_t;

  // Results produced by one word, oldest in first.
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

  function automatic logic [31:0] flip32(input logic [31:0] v);
    flip32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

// File: design/spvep_parser.sv
// Parser: module word decoding, parse state and per-word result generation.
`timescale 1ns / 1ps

module spvep_parser import spvep_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  input  logic [31:0] word,
  input  logic        end_of_module,
  output push_t       push
);

  logic        swap_bytes, swap_bytes_next;
  logic        bad_magic_seen, bad_magic_seen_next;
  logic        malformed_seen, malformed_seen_next;
  logic [2:0]  header_position, header_position_next;
  logic [15:0] words_left, words_left_next;
  logic [15:0] word_in_instr, word_in_instr_next;
  logic [15:0] current_opcode, current_opcode_next;
  logic [2:0]  entry_model, entry_model_next;
  logic        entry_valid, entry_valid_next;
  logic        mode_is_local_size, mode_is_local_size_next;
  logic [31:0] target_id, target_id_next;
  logic [31:0] saved_x, saved_x_next;
  logic [31:0] saved_y, saved_y_next;
  logic [5:0]  stage_accum, stage_accum_next;

  logic [31:0] w;
  logic [5:0]  stage_bit;
  logic        rec_hit;
  res_t        rec;
  res_t        summary;

  assign w         = swap_bytes ? flip32(word) : word;
  assign stage_bit = 6'b00_0001 << entry_model;

  always_comb begin
    swap_bytes_next         = swap_bytes;
    bad_magic_seen_next     = bad_magic_seen;
    malformed_seen_next     = malformed_seen;
    header_position_next    = header_position;
    words_left_next         = words_left;
    word_in_instr_next      = word_in_instr;
    current_opcode_next     = current_opcode;
    entry_model_next        = entry_model;
    entry_valid_next        = entry_valid;
    mode_is_local_size_next = mode_is_local_size;
    target_id_next          = target_id;
    saved_x_next            = saved_x;
    saved_y_next            = saved_y;
    stage_accum_next        = stage_accum;
    rec_hit                 = 1'b0;
    rec                     = '0;
    summary                 = '0;

    if (valid && !bad_magic_seen && !malformed_seen) begin
      if (header_position == 3'd0) begin
        if (word == MAGIC_WORD) begin
          swap_bytes_next = 1'b0;
        end else if (word == flip32(MAGIC_WORD)) begin
          swap_bytes_next = 1'b1;
        end else begin
          bad_magic_seen_next = 1'b1;
        end
        header_position_next = 3'd1;
      end else if (header_position <= HEADER_WORDS) begin
        header_position_next = header_position + 3'd1;
      end else if (words_left == 16'd0) begin
        if (w[31:16] == 16'd0) begin
          malformed_seen_next = 1'b1;
        end else begin
          words_left_next         = w[31:16] - 16'd1;
          word_in_instr_next      = 16'd1;
          current_opcode_next     = w[15:0];
          entry_valid_next        = 1'b0;
          mode_is_local_size_next = 1'b0;
        end
      end else begin
        words_left_next = words_left - 16'd1;
        if (word_in_instr != 16'hFFFF) begin
          word_in_instr_next = word_in_instr + 16'd1;
        end
        case (current_opcode)
          OP_ENTRY_POINT: begin
            if (word_in_instr == 16'd1) begin
              entry_valid_next = (w < MODEL_LIMIT);
              entry_model_next = w[2:0];
            end else if (word_in_instr == 16'd2 && entry_valid) begin
              stage_accum_next = stage_accum | stage_bit;
              rec_hit          = 1'b1;
              rec.kind         = KIND_ENTRY;
              rec.result_id    = w;
              rec.stage_mask   = {25'd0, stage_bit};
            end
          end
          OP_EXEC_MODE: begin
            case (word_in_instr)
              16'd1: target_id_next = w;
              16'd2: mode_is_local_size_next = (w == MODE_LOCAL_SIZE);
              16'd3: saved_x_next = w;
              16'd4: saved_y_next = w;
              16'd5: begin
                if (mode_is_local_size) begin
                  rec_hit       = 1'b1;
                  rec.kind      = KIND_LOCAL_SIZE;
                  rec.result_id = target_id;
                  rec.size_x    = saved_x;
                  rec.size_y    = saved_y;
                  rec.size_z    = w;
                end
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
    end

    rec.last_of_run     = !end_of_module;
    summary.kind        = KIND_SUMMARY;
    summary.last_of_run = 1'b1;
    if (bad_magic_seen_next) begin
      summary.status     = STATUS_BAD_MAGIC;
      summary.stage_mask = '0;
    end else if (malformed_seen_next || header_position_next <= HEADER_WORDS ||
                 words_left_next != 16'd0) begin
      summary.status     = STATUS_MALFORMED;
      summary.stage_mask = ALL_STAGES;
    end else begin
      summary.status     = STATUS_OK;
      summary.stage_mask = (stage_accum_next != 6'd0) ? {25'd0, stage_accum_next}
                                                      : ALL_STAGES;
    end

    push.first  = rec_hit ? rec : summary;
    push.second = summary;
    if (!valid) begin
      push.count = 2'd0;
    end else begin
      push.count = {1'b0, rec_hit} + {1'b0, end_of_module};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (valid && end_of_module)) begin
      swap_bytes         <= 1'b0;
      bad_magic_seen     <= 1'b0;
      malformed_seen     <= 1'b0;
      header_position    <= '0;
      words_left         <= '0;
      word_in_instr      <= '0;
      current_opcode     <= '0;
      entry_model        <= '0;
      entry_valid        <= 1'b0;
      mode_is_local_size <= 1'b0;
      target_id          <= '0;
      saved_x            <= '0;
      saved_y            <= '0;
      stage_accum        <= '0;
    end else begin
      swap_bytes         <= swap_bytes_next;
      bad_magic_seen     <= bad_magic_seen_next;
      malformed_seen     <= malformed_seen_next;
      header_position    <= header_position_next;
      words_left         <= words_left_next;
      word_in_instr      <= word_in_instr_next;
      current_opcode     <= current_opcode_next;
      entry_model        <= entry_model_next;
      entry_valid        <= entry_valid_next;
      mode_is_local_size <= mode_is_local_size_next;
      target_id          <= target_id_next;
      saved_x            <= saved_x_next;
      saved_y            <= saved_y_next;
      stage_accum        <= stage_accum_next;
    end
  end

endmodule

// File: design/spirv_entry_point_scanner.sv
// Top level: input register, parser and result queue of the SPIR-V entry point scanner.
//
//  channel | dir | tdata                          | tlast         | tuser
//  s_*     | in  | word                           | end_of_module | -
//  m_*     | out | result_id, stage_mask, size_x, | last_of_run   | kind
//          |     | size_y, size_z, status         |               |
//
// One word per cycle while s_tready is high, set by the parser updating its state on
// the registered word. A result is offered once the parser writes it to the queue.
// A word may yield two results; an 8-entry result queue absorbs them, and s_tready
// drops only when it could not take a new word's output beside the registered word's.
// Reset (rst, synchronous) empties the queue and returns to word 0 of a module.
`timescale 1ns / 1ps

module spirv_entry_point_scanner import spvep_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [31:0]            s_tdata,  // word
  input  logic                   s_tlast,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [RES_TDATA_W-1:0] m_tdata,  // result_id, stage_mask, size_x, size_y, size_z, status
  output logic                   m_tlast,
  output logic [1:0]             m_tuser   // kind
);

  localparam int QDEPTH = 8;
  localparam int QAW    = $clog2(QDEPTH);

  logic              in_valid;
  logic [31:0]       in_word;
  logic              in_last;
  push_t             push;
  res_t              queue [QDEPTH];
  logic [QAW-1:0]    wr_ptr, rd_ptr;
  logic [QAW:0]      count, count_next;
  logic [QAW:0]      reserve;
  logic              pop;
  res_t              head;

  assign reserve  = count + (in_valid ? (QAW+1)'(2) : (QAW+1)'(0));
  assign s_tready = reserve <= (QAW+1)'(QDEPTH - 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= s_tvalid && s_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_word <= s_tdata;
      in_last <= s_tlast;
    end
  end

  spvep_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .valid         (in_valid),
    .word          (in_word),
    .end_of_module (in_last),
    .push          (push)
  );

  assign head     = queue[rd_ptr];
  assign m_tvalid = count != '0;
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = {7'd0, head.status, head.size_z, head.size_y, head.size_x,
                     head.stage_mask, head.result_id};
  assign m_tlast  = head.last_of_run;
  assign m_tuser  = head.kind;

  assign count_next = count + (QAW+1)'(push.count) - (pop ? (QAW+1)'(1) : (QAW+1)'(0));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QAW'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      queue[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      queue[wr_ptr + QAW'(1)] <= push.second;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (QAW+2)'(count) + (QAW+2)'(push.count) <= (QAW+2)'(QDEPTH))
    else $error("result queue overflow");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> push.first.kind != KIND_SUMMARY && push.second.kind == KIND_SUMMARY)
    else $error("summary not last of a result pair");

  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_SUMMARY |-> m_tlast)
    else $error("summary without last_of_run");

  a_push_needs_word: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> push.count == 2'd0)
    else $error("result pushed without a word");

endmodule
